// ===== rtl/flu_pkg.sv =====
// Shared types and constants of the frame loader.
// Used by the front and back ends, the queue and the top level.
package flu_pkg;

  // Input operation codes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result kinds and exit causes
  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_EXIT     = 1'b1;
  localparam logic CAUSE_PATTERN = 1'b0;
  localparam logic CAUSE_TIMEOUT = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_INIT    = 2'd2;

  // Register reset values
  localparam logic [15:0] START_RESET   = 16'hC00;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd5;
  localparam logic [4:0]  INIT_RESET    = 5'd10;

  // Unlock pattern step between frames
  localparam logic [8:0] PATTERN_STEP = 9'd10;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_EXIT  = 2'd2
  } cmd_op_e;

  // One command from the front end to the back end
  typedef struct packed {
    cmd_op_e     op;
    logic        cause;
    logic [63:0] data;
  } cmd_t;

  // Live configuration seen by the front end
  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [4:0] init_frames;
  } front_cfg_t;

  // Load of the block address by a start address write
  typedef struct packed {
    logic        load;
    logic [15:0] value;
  } addr_load_t;

  // Front end status
  typedef struct packed {
    logic finished;
    logic push;
  } front_stat_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== rtl/flu_ifs.sv =====
// Valid/ready channel interfaces of the frame loader: input items and result items.
// Depends on nothing but plain logic types.
interface flu_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] frame_data;

  modport source (output valid, output op, output frame_data, input ready);
  modport sink   (input valid, input op, input frame_data, output ready);
endinterface

interface flu_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] word_address;
  logic [63:0] word_data;
  logic        erase_first;
  logic        exit_cause;
  logic        last;

  modport source (output valid, output kind, output word_address, output word_data,
                  output erase_first, output exit_cause, output last, input ready);
  modport sink   (input valid, input kind, input word_address, input word_data,
                  input erase_first, input exit_cause, input last, output ready);
endinterface

// ===== rtl/frame_loader_with_unlock_and_timeout_core.sv =====
// Frame loader top level: configuration registers, front end, command queue, back end.
// Depends on flu_pkg, flu_ifs, flu_front, flu_queue and flu_back.
//
// Usage: frames and ticks enter on in_i; the first init_frames frames must carry the
// unlock pattern, later frames are buffered and every BLOCK_BYTES/8-th frame releases
// a block of BLOCK_BYTES/8 word writes on out_o, the first flagged for erase. A bad
// pattern or timeout_ticks idle ticks gives one exit result, after which items are
// accepted and dropped. Each item is accepted while the four-entry command queue
// has room; a full block drains one word per cycle, while the output slot is free,
// from the block buffer's read port, and a stalled output stalls the back end and,
// once the queue fills, the input. Configure only while idle; there is no clearing
// pass after reset.
module frame_loader_with_unlock_and_timeout_core import flu_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flu_in_if.sink      in_i,
  flu_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] start_q;
  logic [7:0]  timeout_q;
  logic [4:0]  init_q;
  logic        cfg_wr, qpop;
  front_cfg_t  fcfg;
  addr_load_t  addr_load;
  front_stat_t fstat;
  queue_stat_t qstat;
  cmd_t        push_cmd, pop_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= START_RESET;
      timeout_q <= TIMEOUT_RESET;
      init_q    <= INIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_START:   start_q   <= pwdata[15:0];
        REG_TIMEOUT: timeout_q <= pwdata[7:0];
        REG_INIT:    init_q    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Return register values on reads
  always_comb begin
    case (paddr[3:2])
      REG_START:   prdata = {16'd0, start_q};
      REG_TIMEOUT: prdata = {24'd0, timeout_q};
      REG_INIT:    prdata = {27'd0, init_q};
      default:     prdata = '0;
    endcase
  end

  assign fcfg.timeout_ticks = timeout_q;
  assign fcfg.init_frames   = init_q;
  assign addr_load.load     = cfg_wr && (paddr[3:2] == REG_START);
  assign addr_load.value    = pwdata[15:0];

  flu_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (fcfg),
    .qstat_i (qstat),
    .cmd_o   (push_cmd),
    .stat_o  (fstat)
  );

  flu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fstat.push),
    .push_data_i (push_cmd),
    .pop_i       (qpop),
    .pop_data_o  (pop_cmd),
    .stat_o      (qstat)
  );

  flu_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .qstat_i     (qstat),
    .pop_o       (qpop),
    .addr_load_i (addr_load),
    .out_o       (out_o)
  );

  // Nothing is issued once loading has ended
  a_no_push_after_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.finished |-> !fstat.push)
    else $error("command issued after exit");

  // The queue never takes a command while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !fstat.push)
    else $error("push into full queue");

  // An exit result only shows after the front end has ended loading
  a_exit_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == KIND_EXIT)) |-> fstat.finished)
    else $error("exit result without finished loader");

  // Loading ends only on an accepted item
  a_finish_on_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fstat.finished) |-> $past(in_i.valid && in_i.ready))
    else $error("loader finished without an item");

endmodule

// ===== rtl/flu_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on flu_pkg for the command type and depth.
module flu_queue import flu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cmd_t        push_data_i,
  input  logic        pop_i,
  output cmd_t        pop_data_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign stat_o.full  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/flu_front.sv =====
// Front end: accepts frames and ticks, checks the unlock pattern, keeps the idle
// timer and issues store, flush and exit commands. Depends on flu_pkg and flu_ifs.
module flu_front import flu_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flu_in_if.sink      in_i,
  input  front_cfg_t  cfg_i,
  input  queue_stat_t qstat_i,
  output cmd_t        cmd_o,
  output front_stat_t stat_o
);

  localparam int unsigned Words = BLOCK_BYTES / 8;
  localparam int unsigned CntW  = $clog2(Words);

  logic [4:0]      unlock_q, unlock_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [7:0]      idle_q, idle_d, idle_inc;
  logic            finished_q, finished_d;
  logic            accept, push, pattern_ok;
  logic [8:0]      base;

  assign in_i.ready = finished_q || !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  // Check byte i against unlock_count*10+i; values past 255 never match
  always_comb begin
    base       = 9'(unlock_q) * PATTERN_STEP;
    pattern_ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if ({1'b0, in_i.frame_data[8*i +: 8]} != base + 9'(i)) begin
        pattern_ok = 1'b0;
      end
    end
  end

  assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;

  // Classify the item and build the command
  always_comb begin
    unlock_d   = unlock_q;
    fill_d     = fill_q;
    idle_d     = idle_q;
    finished_d = finished_q;
    push       = 1'b0;
    cmd_o.op    = CMD_STORE;
    cmd_o.cause = CAUSE_PATTERN;
    cmd_o.data  = in_i.frame_data;
    if (accept && !finished_q) begin
      if (in_i.op == OP_TICK) begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.timeout_ticks) begin
          finished_d  = 1'b1;
          push        = 1'b1;
          cmd_o.op    = CMD_EXIT;
          cmd_o.cause = CAUSE_TIMEOUT;
        end
      end else begin
        idle_d = '0;
        if (unlock_q < cfg_i.init_frames) begin
          if (pattern_ok) begin
            unlock_d = unlock_q + 5'd1;
          end else begin
            finished_d = 1'b1;
            push       = 1'b1;
            cmd_o.op   = CMD_EXIT;
          end
        end else begin
          push = 1'b1;
          if (fill_q == CntW'(Words - 1)) begin
            cmd_o.op = CMD_FLUSH;
            fill_d   = '0;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
    end
  end

  assign stat_o.finished = finished_q;
  assign stat_o.push     = push;

  // Hold loader state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_q   <= '0;
      fill_q     <= '0;
      idle_q     <= '0;
      finished_q <= 1'b0;
    end else begin
      unlock_q   <= unlock_d;
      fill_q     <= fill_d;
      idle_q     <= idle_d;
      finished_q <= finished_d;
    end
  end

endmodule

// ===== rtl/flu_back.sv =====
// Back end: fills the block buffer, drains full blocks as word writes and sends
// exit results through the output register. Depends on flu_pkg and flu_ifs.
module flu_back import flu_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  queue_stat_t qstat_i,
  output logic        pop_o,
  input  addr_load_t  addr_load_i,
  flu_out_if.source   out_o
);

  localparam int unsigned Words = BLOCK_BYTES / 8;
  localparam int unsigned IdxW  = $clog2(Words);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_e;

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] wptr_q, wptr_d, word_q, word_d;
  logic [15:0]     addr_q, addr_d;
  logic [63:0]     buffer [Words];
  logic [63:0]     rdata_q;
  logic            slot_free, pop, load_out;
  logic            out_valid_q;
  logic            kind_d, erase_d, cause_d, last_d;
  logic [15:0]     waddr_d;
  logic [63:0]     wdata_d;

  assign slot_free = !out_valid_q || out_o.ready;
  assign pop = !qstat_i.empty && (state_q == ST_IDLE) &&
               ((cmd_i.op != CMD_EXIT) || slot_free);
  assign pop_o = pop;

  // Sequence commands and the block drain
  always_comb begin
    state_d  = state_q;
    wptr_d   = wptr_q;
    word_d   = word_q;
    addr_d   = addr_q;
    load_out = 1'b0;
    kind_d   = KIND_WRITE;
    waddr_d  = addr_q + 16'({word_q, 3'b000});
    wdata_d  = rdata_q;
    erase_d  = (word_q == '0);
    cause_d  = CAUSE_PATTERN;
    last_d   = (word_q == IdxW'(Words - 1));
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (cmd_i.op)
            CMD_STORE: wptr_d = wptr_q + 1'b1;
            CMD_FLUSH: begin
              wptr_d  = '0;
              word_d  = '0;
              state_d = ST_DRAIN;
            end
            CMD_EXIT: begin
              load_out = 1'b1;
              kind_d   = KIND_EXIT;
              waddr_d  = '0;
              wdata_d  = '0;
              erase_d  = 1'b0;
              cause_d  = cmd_i.cause;
              last_d   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (word_q == IdxW'(Words - 1)) begin
            state_d = ST_IDLE;
            addr_d  = addr_q + 16'(BLOCK_BYTES);
          end else begin
            word_d = word_q + 1'b1;
          end
        end
      end
    endcase
    if (addr_load_i.load) begin
      addr_d = addr_load_i.value;
    end
  end

  // Write the buffer and prefetch the next word to send
  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.op != CMD_EXIT)) begin
      buffer[wptr_q] <= cmd_i.data;
    end
    rdata_q <= buffer[word_d];
  end

  // Hold the output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.kind         <= kind_d;
      out_o.word_address <= waddr_d;
      out_o.word_data    <= wdata_d;
      out_o.erase_first  <= erase_d;
      out_o.exit_cause   <= cause_d;
      out_o.last         <= last_d;
    end
  end

  assign out_o.valid = out_valid_q;

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      word_q      <= '0;
      addr_q      <= START_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      word_q  <= word_d;
      addr_q  <= addr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
